// ===== rtl/fpsa_pkg.sv =====
// Shared types and codes for the fit-policy segment allocator.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package fpsa_pkg;

  localparam logic [7:0] FREE_MARK = 8'd46;  // '.' marks a free unit

  // Request kinds
  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_COMPACT = 2'd2;
  localparam logic [1:0] REQ_SHOW    = 2'd3;

  // Fit policies
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 72;

  // Controller -> datapath
  typedef struct packed {
    logic load_req;     // latch request, rewind counters
    logic clear_step;   // write free mark at scan index
    logic read_step;    // read unit at scan index
    logic run_close;    // close the pending free run at end of map
    logic alloc_write;  // write owner into the picked run
    logic fill_step;    // write free mark at compaction pointer
    logic push;         // load the result register
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [1:0] req_kind;
    logic       req_invalid;
    logic       clear_last;
    logic       scan_last;
    logic       chunk_last;
    logic       show_done;
    logic       found;
    logic       alloc_last;
    logic       fill_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/fpsa_datapath.sv =====
// Datapath of the segment allocator: unit owner memory, scan counters,
// run tracking, compaction pointer, show word assembly and result register.
// Depends on fpsa_pkg.
`default_nettype none

module fpsa_datapath #(
  parameter int MEM_UNITS = 64
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire fpsa_pkg::dp_cmd_t cmd,
  output fpsa_pkg::dp_status_t   sts,
  input  wire  [1:0]             in_req_type,
  input  wire  [7:0]             in_owner_name,
  input  wire  [6:0]             in_alloc_size,
  input  wire  [1:0]             in_fit_mode,
  output logic [1:0]             out_status,
  output logic [5:0]             out_start_unit,
  output logic [63:0]            out_owners_packed,
  output logic                   out_last_result
);
  import fpsa_pkg::*;

  localparam int AW = (MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1;
  localparam int CW = $clog2(MEM_UNITS + 1);
  localparam int SW = (CW > 7) ? CW : 7;
  localparam int SHOW_UNITS = (MEM_UNITS < 64) ? MEM_UNITS : 64;

  logic [7:0] mem [MEM_UNITS];

  // latched request
  logic [1:0] req_kind;
  logic [7:0] req_name;
  logic [6:0] req_size;
  logic [1:0] req_mode;

  logic [CW-1:0] idx;
  logic          rd_valid;
  logic [AW-1:0] rd_idx;
  logic [7:0]    rd_data;

  logic [AW-1:0] run_start;
  logic [CW-1:0] run_len;
  logic [AW-1:0] pick;
  logic [CW-1:0] pick_len;
  logic          found;
  logic [CW-1:0] wr_ptr;
  logic [63:0]   show_word;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          req_invalid;
  logic          run_fits;
  logic          run_take;
  logic          end_run;
  logic          rd_is_free;
  logic          is_alloc;
  logic          is_show;

  assign is_alloc   = (req_kind == REQ_ALLOC);
  assign is_show    = (req_kind == REQ_SHOW);
  assign rd_is_free = (rd_data == FREE_MARK);

  assign req_invalid = (is_alloc && (req_size == 7'd0 || req_name == FREE_MARK ||
                                     req_mode > FIT_WORST)) ||
                       (req_kind == REQ_FREE && req_name == FREE_MARK);

  // Run evaluation, shared by a used unit and the end of the map
  always_comb begin
    run_fits = SW'(run_len) >= SW'(req_size);
    case (req_mode)
      FIT_FIRST: run_take = run_fits && !found;
      FIT_BEST:  run_take = run_fits && (!found || run_len < pick_len);
      default:   run_take = run_fits && (!found || run_len > pick_len);
    endcase
  end

  assign end_run = cmd.run_close || (rd_valid && is_alloc && !rd_is_free);

  // Single write port
  always_comb begin
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = FREE_MARK;
    if (cmd.clear_step) begin
      we = 1'b1;
    end else if (cmd.alloc_write) begin
      we    = 1'b1;
      waddr = pick + wr_ptr[AW-1:0];
      wdata = req_name;
    end else if (cmd.fill_step) begin
      we    = 1'b1;
      waddr = wr_ptr[AW-1:0];
    end else if (rd_valid && req_kind == REQ_FREE && rd_data == req_name) begin
      we    = 1'b1;
      waddr = rd_idx;
    end else if (rd_valid && req_kind == REQ_COMPACT && !rd_is_free) begin
      // wr_ptr trails the read index, so unread units are never overwritten
      we    = 1'b1;
      waddr = wr_ptr[AW-1:0];
      wdata = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.read_step;
      if (cmd.load_req) begin
        idx <= '0;
      end else if (cmd.clear_step || cmd.read_step) begin
        idx <= idx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= idx[AW-1:0];
    if (cmd.load_req) begin
      req_kind  <= in_req_type;
      req_name  <= in_owner_name;
      req_size  <= in_alloc_size;
      req_mode  <= in_fit_mode;
      run_len   <= '0;
      found     <= 1'b0;
      wr_ptr    <= '0;
      show_word <= '0;
    end else begin
      // free run tracking for allocate
      if (end_run) begin
        if (run_take) begin
          pick     <= run_start;
          pick_len <= run_len;
          found    <= 1'b1;
        end
        run_len <= '0;
      end else if (rd_valid && is_alloc) begin
        if (run_len == '0) begin
          run_start <= rd_idx;
        end
        run_len <= run_len + CW'(1);
      end

      if (cmd.alloc_write || cmd.fill_step ||
          (rd_valid && req_kind == REQ_COMPACT && !rd_is_free)) begin
        wr_ptr <= wr_ptr + CW'(1);
      end

      if (cmd.push) begin
        show_word <= '0;
      end else if (rd_valid && is_show) begin
        show_word[{rd_idx[2:0], 3'b000} +: 8] <= rd_data;
      end
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (req_invalid) begin
        out_status <= ST_INVALID;
      end else if (is_alloc && !found) begin
        out_status <= ST_NO_FIT;
      end else begin
        out_status <= ST_DONE;
      end
      out_start_unit    <= (is_alloc && !req_invalid && found) ? 6'(pick) : 6'd0;
      out_owners_packed <= is_show ? show_word : 64'd0;
      out_last_result   <= !is_show || (idx == CW'(SHOW_UNITS));
    end
  end

  always_comb begin
    sts.req_kind    = req_kind;
    sts.req_invalid = req_invalid;
    sts.clear_last  = (idx == CW'(MEM_UNITS - 1));
    sts.scan_last   = (idx == CW'(MEM_UNITS - 1));
    sts.chunk_last  = (idx[2:0] == 3'b111) || (idx == CW'(SHOW_UNITS - 1));
    sts.show_done   = (idx == CW'(SHOW_UNITS));
    sts.found       = found;
    sts.alloc_last  = (SW'(wr_ptr) + SW'(1)) == SW'(req_size);
    sts.fill_done   = (wr_ptr == CW'(MEM_UNITS));
  end

endmodule

`default_nettype wire

// ===== rtl/fpsa_ctrl.sv =====
// Controller state machine of the segment allocator: sequences the
// clearing pass, scans, writes and result pushes; holds the output valid.
// Depends on fpsa_pkg.
`default_nettype none

module fpsa_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire                   out_ready,
  output fpsa_pkg::dp_cmd_t     cmd,
  input  wire fpsa_pkg::dp_status_t sts
);
  import fpsa_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DRAIN,
    S_CLOSE,
    S_ALLOC_WR,
    S_FILL,
    S_RESP,
    S_SHOW_RD,
    S_SHOW_DRAIN,
    S_SHOW_PUSH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.req_invalid) begin
          state_next = S_RESP;
        end else if (sts.req_kind == REQ_SHOW) begin
          state_next = S_SHOW_RD;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.read_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        case (sts.req_kind)
          REQ_ALLOC:   state_next = S_CLOSE;
          REQ_COMPACT: state_next = S_FILL;
          default:     state_next = S_RESP;
        endcase
      end
      S_CLOSE: begin
        cmd.run_close = 1'b1;
        state_next    = S_ALLOC_WR;
      end
      S_ALLOC_WR: begin
        if (!sts.found) begin
          state_next = S_RESP;
        end else begin
          cmd.alloc_write = 1'b1;
          if (sts.alloc_last) begin
            state_next = S_RESP;
          end
        end
      end
      S_FILL: begin
        if (sts.fill_done) begin
          state_next = S_RESP;
        end else begin
          cmd.fill_step = 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SHOW_RD: begin
        cmd.read_step = 1'b1;
        if (sts.chunk_last) begin
          state_next = S_SHOW_DRAIN;
        end
      end
      S_SHOW_DRAIN: begin
        state_next = S_SHOW_PUSH;
      end
      S_SHOW_PUSH: begin
        if (out_free) begin
          cmd.push   = 1'b1;
          state_next = sts.show_done ? S_IDLE : S_SHOW_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fit_policy_segment_allocator.sv =====
// Contiguous segment allocator (first, best or worst fit) over an owner map.
// Top level: joins fpsa_ctrl and fpsa_datapath. Depends on fpsa_pkg.
//
// Usage:
//   Requests enter on the s_axis channel, one word per request: allocate,
//   free, compact or show. Results leave on m_axis; allocate, free and
//   compact give one word each, show gives one word per eight units
//   (at most eight words, first 64 units), m_axis_tlast on the final one.
//   The unit map lives in a single-port-write, single-port-read memory with
//   registered read data; every valid request walks it one unit per cycle,
//   a show request pausing after each eight units until its word is loaded;
//   an invalid request skips the walk and goes straight to its result.
//   The next request is accepted once the result is loaded into the output
//   register, even while m_axis is stalled; a stalled output holds the
//   following result back until the register is taken.
//   After reset a clearing pass marks all MEM_UNITS units free, with
//   s_axis_tready low.
`default_nettype none

module fit_policy_segment_allocator #(
  parameter int MEM_UNITS = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[1:0], owner_name[9:2], alloc_size[16:10], fit_mode[18:17], zero pad
  input  wire  [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // status[1:0], start_unit[7:2], owners_packed[71:8]
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import fpsa_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;
  logic [1:0]  res_status;
  logic [5:0]  res_start;
  logic [63:0] res_packed;

  fpsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  fpsa_datapath #(
    .MEM_UNITS (MEM_UNITS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (s_axis_tdata[1:0]),
    .in_owner_name     (s_axis_tdata[9:2]),
    .in_alloc_size     (s_axis_tdata[16:10]),
    .in_fit_mode       (s_axis_tdata[18:17]),
    .out_status        (res_status),
    .out_start_unit    (res_start),
    .out_owners_packed (res_packed),
    .out_last_result   (m_axis_tlast)
  );

  assign m_axis_tdata = {res_packed, res_start, res_status};

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for fit_policy_segment_allocator: directed and random requests
// on s_axis, results on m_axis checked against a local model of the owner map.
// Depends on fpsa_pkg and the allocator RTL.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fpsa_pkg::*;

  localparam int MEM_UNITS    = 64;
  localparam int SHOW_WORDS   = ((MEM_UNITS + 7) / 8 > 8) ? 8 : (MEM_UNITS + 7) / 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_LIMIT  = 3000;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  start;
    logic [63:0] owners;
    logic        tail;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;

  fit_policy_segment_allocator #(.MEM_UNITS(MEM_UNITS)) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // model of the owner map and words still owed by the block
  logic [7:0] unit_map [MEM_UNITS];
  word_t      expected_words [$];

  int mismatches = 0;
  int words_seen = 0;
  int kind_count [4] = '{0, 0, 0, 0};
  int no_fit_count = 0;
  int reject_count = 0;
  int holds_done = 0;

  // sender burst state
  int burst_left = 0;
  bit sender_steady = 1'b0;

  // receiver state
  bit         hold_req = 1'b0;
  int         rx_mode = 0;
  int         rx_phase_left = 0;
  logic [7:0] rx_pattern = 8'hff;
  logic [2:0] rx_cycle = '0;

  int idle_cycles = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("ERROR @%0t word %0d: %s got 0x%0h expected 0x%0h",
               $time, words_seen, what, got, want);
  endtask

  // Applies one request to the map model and queues the words it should produce.
  function automatic void predict_results(input logic [1:0] kind, input logic [7:0] name,
                                          input logic [6:0] size, input logic [1:0] mode);
    word_t w;
    int    i, k, b, wr;
    int    run_start, run_len, pick, pick_len;
    bit    found, take;

    w = '0;
    w.tail = 1'b1;
    run_start = 0;
    run_len = 0;
    pick = 0;
    pick_len = 0;
    found = 1'b0;
    kind_count[kind]++;
    case (kind)
      REQ_ALLOC: begin
        if (size == 0 || name == FREE_MARK || mode > FIT_WORST) begin
          w.status = ST_INVALID;
        end else begin
          // i == MEM_UNITS closes a run that reaches the end of the map
          for (i = 0; i <= MEM_UNITS; i++) begin
            if (i < MEM_UNITS && unit_map[i] == FREE_MARK) begin
              if (run_len == 0) run_start = i;
              run_len++;
            end else begin
              if (run_len >= int'(size)) begin
                case (mode)
                  FIT_FIRST: take = !found;
                  FIT_BEST:  take = !found || run_len < pick_len;
                  default:   take = !found || run_len > pick_len;
                endcase
                if (take) begin
                  pick = run_start;
                  pick_len = run_len;
                  found = 1'b1;
                end
              end
              run_len = 0;
            end
          end
          if (found) begin
            for (i = 0; i < int'(size); i++) unit_map[pick + i] = name;
            w.start = pick[5:0];
          end else begin
            w.status = ST_NO_FIT;
          end
        end
      end
      REQ_FREE: begin
        if (name == FREE_MARK) begin
          w.status = ST_INVALID;
        end else begin
          for (i = 0; i < MEM_UNITS; i++)
            if (unit_map[i] == name) unit_map[i] = FREE_MARK;
        end
      end
      REQ_COMPACT: begin
        wr = 0;
        for (i = 0; i < MEM_UNITS; i++) begin
          if (unit_map[i] != FREE_MARK) begin
            unit_map[wr] = unit_map[i];
            wr++;
          end
        end
        for (i = wr; i < MEM_UNITS; i++) unit_map[i] = FREE_MARK;
      end
      default: ;
    endcase

    if (w.status == ST_NO_FIT) no_fit_count++;
    if (w.status == ST_INVALID) reject_count++;

    if (kind == REQ_SHOW) begin
      for (k = 0; k < SHOW_WORDS; k++) begin
        w = '0;
        for (b = 0; b < 8; b++)
          if (k * 8 + b < MEM_UNITS) w.owners[b*8 +: 8] = unit_map[k * 8 + b];
        w.tail = (k == SHOW_WORDS - 1);
        expected_words.push_back(w);
      end
    end else begin
      expected_words.push_back(w);
    end
  endfunction

  // One request word; gaps between bursts unless the sender is steady.
  task automatic send_req(input logic [1:0] kind, input logic [7:0] name,
                          input logic [6:0] size, input logic [1:0] mode);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = sender_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, mode, size, name, kind};
    do @(posedge clk); while (!s_axis_tready);
    predict_results(kind, name, size, mode);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  task automatic test_empty_map();
    send_req(REQ_SHOW, 8'h00, 7'd0, FIT_FIRST);
    send_req(REQ_ALLOC, "A", 7'd64, FIT_FIRST);   // whole memory in one block
    send_req(REQ_ALLOC, "B", 7'd1, FIT_BEST);     // nothing left
    send_req(REQ_FREE, "A", 7'd0, FIT_FIRST);
  endtask

  task automatic test_rejects();
    send_req(REQ_ALLOC, "R", 7'd0, FIT_FIRST);
    send_req(REQ_ALLOC, FREE_MARK, 7'd4, FIT_FIRST);
    send_req(REQ_ALLOC, "R", 7'd4, 2'd3);         // unknown fit policy
    send_req(REQ_FREE, FREE_MARK, 7'd0, FIT_FIRST);
    send_req(REQ_ALLOC, "R", 7'h7f, FIT_WORST);   // larger than the memory
  endtask

  task automatic test_fit_policies();
    sender_steady = 1'b1;
    send_req(REQ_ALLOC, "A", 7'd10, FIT_FIRST);
    send_req(REQ_ALLOC, "B", 7'd4, FIT_FIRST);
    send_req(REQ_ALLOC, "C", 7'd6, FIT_FIRST);
    send_req(REQ_ALLOC, 8'h00, 7'd2, FIT_FIRST);
    send_req(REQ_ALLOC, 8'hff, 7'd8, FIT_FIRST);
    // holes of 4 and 2 units plus the tail
    send_req(REQ_FREE, "B", 7'd0, FIT_FIRST);
    send_req(REQ_FREE, 8'h00, 7'd0, FIT_FIRST);
    send_req(REQ_ALLOC, "Y", 7'd2, FIT_BEST);
    send_req(REQ_ALLOC, "X", 7'd2, FIT_FIRST);
    send_req(REQ_ALLOC, "Z", 7'd3, FIT_WORST);
    sender_steady = 1'b0;
  endtask

  task automatic test_compact_and_names();
    send_req(REQ_FREE, "A", 7'd0, FIT_FIRST);     // first segment becomes free
    send_req(REQ_COMPACT, 8'h5a, 7'h55, 2'd3);
    send_req(REQ_SHOW, 8'ha5, 7'h2a, FIT_BEST);
    send_req(REQ_ALLOC, "C", 7'd3, FIT_FIRST);    // name already owns units
    send_req(REQ_FREE, "C", 7'd0, FIT_FIRST);
    send_req(REQ_FREE, "Q", 7'd0, FIT_FIRST);     // owns nothing
    send_req(REQ_SHOW, 8'h00, 7'd0, FIT_FIRST);
  endtask

  task automatic test_random(input int count);
    int         n, sel, r;
    logic [7:0] name;
    logic [6:0] size;
    logic [1:0] mode;
    for (n = 0; n < count; n++) begin
      sel  = $urandom_range(0, 99);
      name = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'("A" + $urandom_range(0, 7));
      mode = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      r    = $urandom_range(0, 19);
      if (r == 0)      size = 7'($urandom_range(65, 127));
      else if (r == 1) size = 7'd0;
      else if (r < 5)  size = 7'($urandom_range(17, 64));
      else             size = 7'($urandom_range(1, 16));
      if (sel < 50)      send_req(REQ_ALLOC, name, size, mode);
      else if (sel < 78) send_req(REQ_FREE, name, size, mode);
      else if (sel < 89) send_req(REQ_COMPACT, name, size, mode);
      else               send_req(REQ_SHOW, name, size, mode);
    end
  endtask

  // Receiver stops for a long stretch while requests keep coming.
  task automatic test_backpressure();
    int n;
    wait_idle();
    hold_req = 1'b1;
    for (n = 0; n < 8; n++) begin
      if (n % 2 == 0) send_req(REQ_SHOW, 8'h00, 7'd0, FIT_FIRST);
      else send_req(REQ_ALLOC, 8'("A" + n), 7'($urandom_range(1, 8)), FIT_BEST);
    end
    wait_idle();
  endtask

  // receiver: long hold on request, otherwise phases of its own stall pattern
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        if (rx_phase_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_phase_left = $urandom_range(20, 80);
          rx_pattern = 8'($urandom_range(1, 255));
        end
        rx_phase_left--;
        rx_cycle <= rx_cycle + 3'd1;
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= rx_pattern[rx_cycle];
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_words
    word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata[63:0], 64'd0);
      end else begin
        want = expected_words.pop_front();
        if (m_axis_tdata[1:0] != want.status)
          report_mismatch("status", 64'(m_axis_tdata[1:0]), 64'(want.status));
        if (m_axis_tdata[7:2] != want.start)
          report_mismatch("start_unit", 64'(m_axis_tdata[7:2]), 64'(want.start));
        if (m_axis_tdata[71:8] != want.owners)
          report_mismatch("owners", m_axis_tdata[71:8], want.owners);
        if (m_axis_tlast != want.tail)
          report_mismatch("tlast", 64'(m_axis_tlast), 64'(want.tail));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TIMEOUT: no word moved for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    foreach (unit_map[i]) unit_map[i] = FREE_MARK;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_map();
    test_rejects();
    test_fit_policies();
    test_compact_and_names();
    test_random(33);
    test_backpressure();
    test_random(33);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d allocate, %0d free, %0d compact, %0d show requests; %0d words out",
             kind_count[REQ_ALLOC], kind_count[REQ_FREE], kind_count[REQ_COMPACT],
             kind_count[REQ_SHOW], words_seen);
    $display("Allocations without fit: %0d, rejected requests: %0d, long output holds: %0d",
             no_fit_count, reject_count, holds_done);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
